// ===== hw/rtl/imu_rfc_pkg.sv =====
// ---------------------------------------------------------------------------
// imu_rfc_pkg
// Shared constants and types of the attitude response frame checker: frame
// layout, CRC-16/ARC polynomial and the result record.
// ---------------------------------------------------------------------------
package imu_rfc_pkg;

   // Frame layout
   localparam int FRAME_BYTES  = 28;
   localparam int N_WORDS      = 6;
   localparam int WORD_BYTES   = 4;
   localparam int SHADOW_BYTES = N_WORDS * WORD_BYTES;
   localparam int POS_W        = $clog2(FRAME_BYTES);

   // Byte positions inside a frame
   localparam logic [POS_W-1:0] POS_CMD    = POS_W'(0);
   localparam logic [POS_W-1:0] POS_RESP   = POS_W'(1);
   localparam logic [POS_W-1:0] POS_CHK_LO = POS_W'(2);
   localparam logic [POS_W-1:0] POS_CHK_HI = POS_W'(3);
   localparam logic [POS_W-1:0] POS_WORDS  = POS_W'(4);
   localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_BYTES - 1);

   // Reflected CRC-16/ARC polynomial
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef logic [N_WORDS-1:0][31:0] word_set_type;

   // One result transaction
   typedef struct packed {
      logic         frame_ok;
      logic [7:0]   command_id;
      logic [7:0]   response_id;
      word_set_type words;
   } frame_result_type;

endpackage

// ===== hw/rtl/imu_rfc_crc.sv =====
// ---------------------------------------------------------------------------
// imu_rfc_crc
// One-byte CRC-16/ARC update, reflected, bit by bit over eight steps.
// ---------------------------------------------------------------------------
module imu_rfc_crc (
   input  logic [15:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [15:0] crc_next
);
   import imu_rfc_pkg::*;

   // Fold in the byte, then shift eight times
   always_comb begin
      logic [15:0] acc;
      acc = crc_cur ^ {8'h00, data_byte};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      crc_next = acc;
   end

endmodule

// ===== hw/rtl/imu_rfc_frame.sv =====
// ---------------------------------------------------------------------------
// imu_rfc_frame
// Frame state: byte position, running CRC, header latches, shadow words and
// held attitude. Commits one byte per step and forms the result on the last.
// ---------------------------------------------------------------------------
module imu_rfc_frame (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [7:0]                    rx_byte,
   input  logic                          frame_start,
   output logic                          frame_last,
   output imu_rfc_pkg::frame_result_type result
);
   import imu_rfc_pkg::*;

   logic [POS_W-1:0]                   pos_ff, pos_in;
   logic [15:0]                        crc_ff, crc_in;
   logic [15:0]                        chk_ff, chk_in;
   logic [7:0]                         cmd_ff, cmd_in;
   logic [7:0]                         resp_ff, resp_in;
   logic [SHADOW_BYTES-1:0][7:0]       shadow_ff, shadow_in;
   word_set_type                       held_ff, held_in;

   logic [POS_W-1:0]                   pos_eff;
   logic [POS_W-1:0]                   shadow_idx;
   logic [15:0]                        crc_base;
   logic [7:0]                         fed_byte;
   logic [15:0]                        crc_upd;
   logic                               crc_match;

   // Resolve the position of this byte
   always_comb begin
      if (frame_start || (pos_ff > POS_LAST)) begin
         pos_eff = POS_CMD;
      end else begin
         pos_eff = pos_ff;
      end
      crc_base   = (pos_eff == POS_CMD) ? 16'h0000 : crc_ff;
      shadow_idx = pos_eff - POS_WORDS;
      frame_last = (pos_eff == POS_LAST);
   end

   // Route the byte to its field; check-word bytes feed the CRC as zero
   always_comb begin
      cmd_in    = cmd_ff;
      resp_in   = resp_ff;
      chk_in    = chk_ff;
      shadow_in = shadow_ff;
      fed_byte  = rx_byte;
      priority if (pos_eff == POS_CMD) begin
         cmd_in = rx_byte;
      end else if (pos_eff == POS_RESP) begin
         resp_in = rx_byte;
      end else if (pos_eff == POS_CHK_LO) begin
         chk_in   = {chk_ff[15:8], rx_byte};
         fed_byte = 8'h00;
      end else if (pos_eff == POS_CHK_HI) begin
         chk_in   = {rx_byte, chk_ff[7:0]};
         fed_byte = 8'h00;
      end else begin
         shadow_in[shadow_idx] = rx_byte;
      end
   end

   imu_rfc_crc u_crc (
      .crc_cur   (crc_base),
      .data_byte (fed_byte),
      .crc_next  (crc_upd)
   );

   // Advance position, update held words on a good frame
   always_comb begin
      crc_in    = crc_upd;
      crc_match = (crc_upd == chk_in);
      held_in   = held_ff;
      if (frame_last) begin
         pos_in = POS_CMD;
         if (crc_match) begin
            held_in = word_set_type'(shadow_in);
         end
      end else begin
         pos_in = pos_eff + POS_W'(1);
      end
   end

   // Form the result transaction
   always_comb begin
      result.frame_ok    = crc_match;
      result.command_id  = cmd_in;
      result.response_id = resp_in;
      result.words       = held_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_CMD;
         crc_ff    <= '0;
         chk_ff    <= '0;
         cmd_ff    <= '0;
         resp_ff   <= '0;
         shadow_ff <= '0;
         held_ff   <= '0;
      end else if (step_en) begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         chk_ff    <= chk_in;
         cmd_ff    <= cmd_in;
         resp_ff   <= resp_in;
         shadow_ff <= shadow_in;
         held_ff   <= held_in;
      end
   end

   // Position stays inside the frame
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("frame position out of range");

   // A failed check leaves the held attitude alone
   a_bad_keeps_held: assert property (@(posedge clock) disable iff (reset)
      step_en && frame_last && !crc_match |=> $stable(held_ff))
      else $error("held words changed on a bad frame");

   // A start byte puts the next byte at the response position
   a_start_pos: assert property (@(posedge clock) disable iff (reset)
      step_en && frame_start |=> pos_ff == POS_RESP)
      else $error("frame start did not restart position");

   // Only the last byte returns the position to zero
   a_wrap: assert property (@(posedge clock) disable iff (reset)
      step_en && !frame_last |=> pos_ff != POS_CMD)
      else $error("position wrapped early");

endmodule

// ===== hw/rtl/imu_response_frame_checker.sv =====
// ---------------------------------------------------------------------------
// imu_response_frame_checker
// Receives an attitude sensor response frame byte by byte, checks it with
// CRC-16/ARC and reports the held attitude once per completed frame.
// ---------------------------------------------------------------------------
//   channel  direction  payload                                 handshake
//   req_     in         rx_byte, frame_start                    valid/ready
//   rsp_     out        frame_ok, ids, six held words           valid/ready
//
// One byte per cycle unless a stalled result holds back the last byte: an
// input register feeds the CRC and field update, whose result lands in an
// output register. The last byte waits while that output register is full.
// Synchronous active-high reset clears the frame position, CRC and words.
// A stalled result blocks only the last byte of the next frame; other bytes
// keep flowing while the result waits.
// ---------------------------------------------------------------------------
module imu_response_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_frame_ok,
   output logic [7:0]  rsp_command_id,
   output logic [7:0]  rsp_response_id,
   output logic [31:0] rsp_roll_bits,
   output logic [31:0] rsp_pitch_bits,
   output logic [31:0] rsp_yaw_bits,
   output logic [31:0] rsp_rate_x_bits,
   output logic [31:0] rsp_rate_y_bits,
   output logic [31:0] rsp_rate_z_bits
);
   import imu_rfc_pkg::*;

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_start_ff;
   logic             out_valid_ff, out_valid_in;
   frame_result_type out_ff;
   frame_result_type frame_res;
   logic             frame_last;
   logic             advance;

   // Step the held byte unless its result would overrun a waiting one
   assign advance   = in_valid_ff && (!frame_last || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   imu_rfc_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .rx_byte     (in_byte_ff),
      .frame_start (in_start_ff),
      .frame_last  (frame_last),
      .result      (frame_res)
   );

   // Input register occupancy
   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Output register occupancy
   always_comb begin
      if (advance && frame_last) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the transaction payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_rx_byte;
         in_start_ff <= req_frame_start;
      end
   end

   // Load the result on the last byte
   always_ff @(posedge clock) begin
      if (advance && frame_last) begin
         out_ff <= frame_res;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_frame_ok    = out_ff.frame_ok;
   assign rsp_command_id  = out_ff.command_id;
   assign rsp_response_id = out_ff.response_id;
   assign rsp_roll_bits   = out_ff.words[0];
   assign rsp_pitch_bits  = out_ff.words[1];
   assign rsp_yaw_bits    = out_ff.words[2];
   assign rsp_rate_x_bits = out_ff.words[3];
   assign rsp_rate_y_bits = out_ff.words[4];
   assign rsp_rate_z_bits = out_ff.words[5];

   // A waiting result is never overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !(advance && frame_last))
      else $error("result overwritten while stalled");

   // A new result appears only after a last byte was stepped
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(advance && frame_last))
      else $error("result without a completed frame");

   // A held byte is never dropped without a step
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input byte lost");

endmodule
